// ===== rtl/core/des_pkg.sv =====
// Package for the double-ended stack: field widths, request mode codes,
// result status codes and the structs passed between the core modules.
// No dependencies.
package des_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int VAL_W     = 32;
  localparam int MODE_W    = 3;
  localparam int STAT_W    = 2;

  localparam logic [MODE_W-1:0] MODE_PEEK     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_TOP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_BOT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_TOP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BOT  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  // Result of one request, as produced by the engine in its final cycle.
  typedef struct packed {
    logic              done;
    logic [VAL_W-1:0]  popped_value;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  top_value;
    logic [VAL_W-1:0]  bottom_value;
    logic              is_empty;
  } resp_t;

  // Engine status seen by the top level's handshake logic.
  typedef struct packed {
    logic idle;
  } eng_stat_t;

endpackage

// ===== rtl/core/des_if.sv =====
// Request and result channel interfaces for the double-ended stack.
// Depends on des_pkg for field widths.
interface des_req_if;
  import des_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface des_rsp_if #(parameter int CNT_W = 9);
  import des_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  popped_value;
  logic [STAT_W-1:0]        status;
  logic signed [VAL_W-1:0]  top_value;
  logic signed [VAL_W-1:0]  bottom_value;
  logic [CNT_W-1:0]         item_count;
  logic                     is_empty;

  modport source (output valid, output popped_value, output status, output top_value,
                  output bottom_value, output item_count, output is_empty, input ready);
  modport sink   (input valid, input popped_value, input status, input top_value,
                  input bottom_value, input item_count, input is_empty, output ready);
endinterface

// ===== rtl/core/des_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module des_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/des_engine.sv =====
// Pointer, count and end-value logic of the double-ended stack.
// Drives the entry RAM; depends on des_pkg.
module des_engine #(
  parameter int DEPTH = des_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [des_pkg::MODE_W-1:0]    mode,
  input  logic [des_pkg::VAL_W-1:0]     value,
  output des_pkg::eng_stat_t            stat,
  output des_pkg::resp_t                resp,
  output logic [$clog2(DEPTH+1)-1:0]    count,
  output logic                          wr_en,
  output logic [$clog2(DEPTH)-1:0]      wr_addr,
  output logic [des_pkg::VAL_W-1:0]     wr_data,
  output logic                          rd_en,
  output logic [$clog2(DEPTH)-1:0]      rd_addr,
  input  logic [des_pkg::VAL_W-1:0]     rd_data
);
  import des_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  logic [PTR_W-1:0] top_ptr, top_ptr_next;
  logic [PTR_W-1:0] bot_ptr, bot_ptr_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [VAL_W-1:0] top_val, top_val_next;
  logic [VAL_W-1:0] bot_val, bot_val_next;
  logic             busy, busy_next;
  logic             pend_top, pend_top_next;
  logic [VAL_W-1:0] pend_pop, pend_pop_next;

  logic [PTR_W-1:0] top_up, top_down, bot_up, bot_down;
  logic             is_full, is_none;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  popped;
  logic              done;

  assign top_up   = (top_ptr == LAST) ? '0 : top_ptr + PTR_W'(1);
  assign top_down = (top_ptr == '0) ? LAST : top_ptr - PTR_W'(1);
  assign bot_up   = (bot_ptr == LAST) ? '0 : bot_ptr + PTR_W'(1);
  assign bot_down = (bot_ptr == '0) ? LAST : bot_ptr - PTR_W'(1);
  assign is_full  = (cnt == FULL_CNT);
  assign is_none  = (cnt == '0);

  // A read is only issued in the cycle a pop is taken, and no write happens
  // then, so the RAM never sees a read and a write of one entry together.
  always_comb begin
    top_ptr_next  = top_ptr;
    bot_ptr_next  = bot_ptr;
    cnt_next      = cnt;
    top_val_next  = top_val;
    bot_val_next  = bot_val;
    busy_next     = busy;
    pend_top_next = pend_top;
    pend_pop_next = pend_pop;
    status        = STAT_OK;
    popped        = '0;
    done          = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = top_ptr;
    wr_data       = value;
    rd_en         = 1'b0;
    rd_addr       = top_up;

    if (busy) begin
      // Finish a pop: the new end value arrives from the RAM.
      done      = 1'b1;
      popped    = pend_pop;
      busy_next = 1'b0;
      if (pend_top) begin
        top_val_next = rd_data;
      end else begin
        bot_val_next = rd_data;
      end
    end else if (start) begin
      done = 1'b1;
      case (mode)
        MODE_PUSH_TOP, MODE_PUSH_BOT: begin
          if (is_full) begin
            status = STAT_FULL;
          end else if (is_none) begin
            wr_en        = 1'b1;
            wr_addr      = (mode == MODE_PUSH_TOP) ? top_ptr : bot_ptr;
            top_ptr_next = wr_addr;
            bot_ptr_next = wr_addr;
            top_val_next = value;
            bot_val_next = value;
            cnt_next     = ONE;
          end else if (mode == MODE_PUSH_TOP) begin
            wr_en        = 1'b1;
            wr_addr      = top_down;
            top_ptr_next = top_down;
            top_val_next = value;
            cnt_next     = cnt + ONE;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = bot_up;
            bot_ptr_next = bot_up;
            bot_val_next = value;
            cnt_next     = cnt + ONE;
          end
        end
        MODE_POP_TOP, MODE_POP_BOT: begin
          if (is_none) begin
            status = STAT_UNDERFLOW;
          end else begin
            popped   = (mode == MODE_POP_TOP) ? top_val : bot_val;
            cnt_next = cnt - ONE;
            if (cnt != ONE) begin
              // Fetch the entry that becomes the new end; finish next cycle.
              done          = 1'b0;
              busy_next     = 1'b1;
              rd_en         = 1'b1;
              pend_top_next = (mode == MODE_POP_TOP);
              pend_pop_next = popped;
              if (mode == MODE_POP_TOP) begin
                rd_addr      = top_up;
                top_ptr_next = top_up;
              end else begin
                rd_addr      = bot_down;
                bot_ptr_next = bot_down;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_ptr <= '0;
      bot_ptr <= '0;
      cnt     <= '0;
      busy    <= 1'b0;
    end else begin
      top_ptr <= top_ptr_next;
      bot_ptr <= bot_ptr_next;
      cnt     <= cnt_next;
      busy    <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    top_val  <= top_val_next;
    bot_val  <= bot_val_next;
    pend_top <= pend_top_next;
    pend_pop <= pend_pop_next;
  end

  assign stat.idle          = !busy;
  assign resp.done          = done;
  assign resp.popped_value  = popped;
  assign resp.status        = status;
  assign resp.top_value     = (cnt_next != '0) ? top_val_next : '0;
  assign resp.bottom_value  = (cnt_next != '0) ? bot_val_next : '0;
  assign resp.is_empty      = (cnt_next == '0);
  assign count              = cnt_next;

endmodule

// ===== rtl/core/double_ended_stack.sv =====
// Double-ended stack of signed 32-bit values held in a ring of DEPTH entries.
// Requests arrive on req (mode, value); each gives exactly one result on rsp:
// the popped value, a status, the top and bottom values after the step, the
// item count and an empty flag.
// Modes: peek, push top, push bottom, pop top, pop bottom; other codes peek.
// A pop from an empty stack reports underflow and changes nothing; a push
// onto a full stack reports full and is dropped.
// Peeks, pushes, refused pops and pops of the last item show their result in
// the output register in the cycle after the request is taken. A pop that
// leaves items behind first reads the new end value from the entry RAM, then
// registers its result. Sustained rate is one request per cycle for the other
// requests while rsp is not stalled; a reading pop holds off new requests.
// The result sits in an output register; req.ready stays high while it waits
// if rsp.ready takes it in the same cycle, and drops while rsp is stalled or
// a pop is still reading. Reset empties the stack and clears rsp.valid;
// RAM contents are not cleared, as only entries holding items are read.
// Depends on des_pkg, des_if, des_ram and des_engine.
module double_ended_stack #(
  parameter int DEPTH = des_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  des_req_if.sink     req,
  des_rsp_if.source   rsp
);
  import des_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  eng_stat_t        stat;
  resp_t            resp;
  logic [CNT_W-1:0] count;
  logic             start;
  logic             wr_en, rd_en;
  logic [PTR_W-1:0] wr_addr, rd_addr;
  logic [VAL_W-1:0] wr_data, rd_data;

  assign req.ready = stat.idle && (!rsp.valid || rsp.ready);
  assign start     = req.valid && req.ready;

  des_engine #(.DEPTH(DEPTH)) u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .mode    (req.mode),
    .value   (req.value),
    .stat    (stat),
    .resp    (resp),
    .count   (count),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  des_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (resp.done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp.done) begin
      rsp.popped_value <= resp.popped_value;
      rsp.status       <= resp.status;
      rsp.top_value    <= resp.top_value;
      rsp.bottom_value <= resp.bottom_value;
      rsp.item_count   <= count;
      rsp.is_empty     <= resp.is_empty;
    end
  end

  a_empty_matches_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.is_empty == (rsp.item_count == '0)))
    else $error("empty flag disagrees with item count");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.item_count <= CNT_W'(DEPTH)))
    else $error("item count beyond depth");

  a_underflow_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STAT_UNDERFLOW) |->
      (rsp.popped_value == '0 && rsp.is_empty))
    else $error("refused pop returned data or a non-empty stack");

  a_no_take_while_reading: assert property (@(posedge clk) disable iff (rst)
    (start && !resp.done) |=> (!req.ready && resp.done))
    else $error("pop read did not complete in the following cycle");

endmodule

// ===== tb/double_ended_stack_test.sv =====
// Self-checking testbench for double_ended_stack: directed table then random
// requests, each result compared with the table's expected values or with an in-bench deque predictor.
// Depends on des_pkg, des_req_if, des_rsp_if and the double_ended_stack RTL.
module double_ended_stack_test;
  timeunit 1ns;
  timeprecision 1ps;
  import des_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int STALL_PCT  = 16;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] top;
    logic signed [VAL_W-1:0] bottom;
    logic [CNT_W-1:0]        count;
    logic                    empty;
  } stack_view_t;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [VAL_W-1:0]   value;
    bit                 typed_in;
    stack_view_t        want;
  } plan_row_t;

  logic clk;
  logic rst;

  des_req_if req_ch ();
  des_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

  double_ended_stack #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // predictor state
  logic [VAL_W-1:0] ring_slots [DEPTH];
  int               top_at;
  int               bottom_at;
  int               held;

  stack_view_t      pending_views [$];
  plan_row_t        directed_plan [$];
  int               fails;
  int               quiet_cycles;
  bit               steady;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    fails++;
    if (fails <= 100) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Apply one request to the predictor state and return what the block shows.
  function automatic stack_view_t predict_step(input logic [MODE_W-1:0] m,
                                               input logic [VAL_W-1:0] v);
    stack_view_t r;
    r = '0;
    if (m == MODE_PUSH_TOP || m == MODE_PUSH_BOT) begin
      if (held >= DEPTH) begin
        r.status = STAT_FULL;
      end else if (held == 0) begin
        if (m == MODE_PUSH_TOP) bottom_at = top_at;
        else top_at = bottom_at;
        ring_slots[top_at] = v;
        held = 1;
      end else if (m == MODE_PUSH_TOP) begin
        top_at = (top_at + DEPTH - 1) % DEPTH;
        ring_slots[top_at] = v;
        held++;
      end else begin
        bottom_at = (bottom_at + 1) % DEPTH;
        ring_slots[bottom_at] = v;
        held++;
      end
    end else if (m == MODE_POP_TOP || m == MODE_POP_BOT) begin
      if (held == 0) begin
        r.status = STAT_UNDERFLOW;
      end else if (m == MODE_POP_TOP) begin
        r.popped = ring_slots[top_at];
        held--;
        if (held != 0) top_at = (top_at + 1) % DEPTH;
      end else begin
        r.popped = ring_slots[bottom_at];
        held--;
        if (held != 0) bottom_at = (bottom_at + DEPTH - 1) % DEPTH;
      end
    end
    if (held != 0) begin
      r.top    = ring_slots[top_at];
      r.bottom = ring_slots[bottom_at];
    end
    r.count = held[CNT_W-1:0];
    r.empty = (held == 0);
    return r;
  endfunction

  function automatic plan_row_t row(input logic [MODE_W-1:0] m, input logic [VAL_W-1:0] v,
                                    input bit typed_in, input logic [VAL_W-1:0] popped,
                                    input logic [STAT_W-1:0] status,
                                    input logic [VAL_W-1:0] top,
                                    input logic [VAL_W-1:0] bottom, input int count);
    plan_row_t p;
    p.mode        = m;
    p.value       = v;
    p.typed_in    = typed_in;
    p.want.popped = popped;
    p.want.status = status;
    p.want.top    = top;
    p.want.bottom = bottom;
    p.want.count  = count[CNT_W-1:0];
    p.want.empty  = (count == 0);
    return p;
  endfunction

  // Hold the request until taken, then record what it should produce.
  task automatic send_request(input logic [MODE_W-1:0] m, input logic [VAL_W-1:0] v,
                              input bit typed_in, input stack_view_t want);
    stack_view_t predicted;
    while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= m;
    req_ch.value <= v;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predicted = predict_step(m, v);
    pending_views.push_back(typed_in ? want : predicted);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_random(input logic [MODE_W-1:0] m);
    send_request(m, pick_value(), 1'b0, '0);
  endtask

  function automatic logic [MODE_W-1:0] any_push();
    return $urandom_range(0, 1) ? MODE_PUSH_TOP : MODE_PUSH_BOT;
  endfunction

  function automatic logic [MODE_W-1:0] any_pop();
    return $urandom_range(0, 1) ? MODE_POP_TOP : MODE_POP_BOT;
  endfunction

  // result side: random back-pressure and in-order compare
  always @(posedge clk) begin
    stack_view_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_views.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_views.pop_front();
        if (rsp_ch.popped_value !== want.popped)
          report_mismatch($sformatf("popped_value got %0d want %0d",
                                    rsp_ch.popped_value, want.popped));
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
        if (rsp_ch.top_value !== want.top)
          report_mismatch($sformatf("top_value got %0d want %0d",
                                    rsp_ch.top_value, want.top));
        if (rsp_ch.bottom_value !== want.bottom)
          report_mismatch($sformatf("bottom_value got %0d want %0d",
                                    rsp_ch.bottom_value, want.bottom));
        if (rsp_ch.item_count !== want.count)
          report_mismatch($sformatf("item_count got %0d want %0d",
                                    rsp_ch.item_count, want.count));
        if (rsp_ch.is_empty !== want.empty)
          report_mismatch($sformatf("is_empty got %0b want %0b", rsp_ch.is_empty, want.empty));
      end
    end
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t p;
    int        extra;
    fails        = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    top_at       = 0;
    bottom_at    = 0;
    held         = 0;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_PEEK;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;

    // mode, value, typed, popped, status, top, bottom, count
    directed_plan.push_back(row(MODE_PEEK, 32'h1234_5678, 1, 0, STAT_OK, 0, 0, 0));
    directed_plan.push_back(row(MODE_POP_TOP, 32'hFFFF_FFFF, 1, 0, STAT_UNDERFLOW, 0, 0, 0));
    directed_plan.push_back(row(MODE_POP_BOT, 32'h8000_0000, 1, 0, STAT_UNDERFLOW, 0, 0, 0));
    directed_plan.push_back(row(3'd5, 32'h0000_0001, 1, 0, STAT_OK, 0, 0, 0));
    directed_plan.push_back(row(MODE_PUSH_TOP, 32'h8000_0000, 1, 0, STAT_OK,
                                32'h8000_0000, 32'h8000_0000, 1));
    directed_plan.push_back(row(MODE_PUSH_BOT, 32'h7FFF_FFFF, 1, 0, STAT_OK,
                                32'h8000_0000, 32'h7FFF_FFFF, 2));
    directed_plan.push_back(row(MODE_PUSH_TOP, 32'hFFFF_FFFF, 1, 0, STAT_OK,
                                32'hFFFF_FFFF, 32'h7FFF_FFFF, 3));
    directed_plan.push_back(row(MODE_PUSH_BOT, 32'h0, 1, 0, STAT_OK, 32'hFFFF_FFFF, 0, 4));
    directed_plan.push_back(row(3'd6, 32'hDEAD_BEEF, 1, 0, STAT_OK, 32'hFFFF_FFFF, 0, 4));
    directed_plan.push_back(row(3'd7, 32'h7FFF_FFFF, 1, 0, STAT_OK, 32'hFFFF_FFFF, 0, 4));
    directed_plan.push_back(row(MODE_PEEK, 32'h8000_0000, 1, 0, STAT_OK, 32'hFFFF_FFFF, 0, 4));
    directed_plan.push_back(row(MODE_POP_TOP, 32'h0, 1, 32'hFFFF_FFFF, STAT_OK,
                                32'h8000_0000, 0, 3));
    directed_plan.push_back(row(MODE_POP_BOT, 32'h0, 1, 0, STAT_OK,
                                32'h8000_0000, 32'h7FFF_FFFF, 2));
    directed_plan.push_back(row(MODE_POP_BOT, 32'h0, 1, 32'h7FFF_FFFF, STAT_OK,
                                32'h8000_0000, 32'h8000_0000, 1));
    // last item out leaves the pointers in place
    directed_plan.push_back(row(MODE_POP_TOP, 32'h0, 1, 32'h8000_0000, STAT_OK, 0, 0, 0));
    directed_plan.push_back(row(MODE_PUSH_BOT, 32'h1, 1, 0, STAT_OK, 1, 1, 1));
    directed_plan.push_back(row(MODE_POP_BOT, 32'h0, 1, 1, STAT_OK, 0, 0, 0));
    directed_plan.push_back(row(MODE_PUSH_TOP, 32'h5555_5555, 1, 0, STAT_OK,
                                32'h5555_5555, 32'h5555_5555, 1));
    directed_plan.push_back(row(MODE_PUSH_BOT, 32'hAAAA_AAAA, 1, 0, STAT_OK,
                                32'h5555_5555, 32'hAAAA_AAAA, 2));
    directed_plan.push_back(row(MODE_POP_TOP, 32'h0, 1, 32'h5555_5555, STAT_OK,
                                32'hAAAA_AAAA, 32'hAAAA_AAAA, 1));
    directed_plan.push_back(row(MODE_POP_TOP, 32'h0, 1, 32'hAAAA_AAAA, STAT_OK, 0, 0, 0));
    directed_plan.push_back(row(MODE_POP_TOP, 32'h0, 1, 0, STAT_UNDERFLOW, 0, 0, 0));
    directed_plan.push_back(row(MODE_PUSH_TOP, 32'h1234_5678, 0, 0, STAT_OK, 0, 0, 0));
    directed_plan.push_back(row(MODE_PUSH_BOT, 32'h8765_4321, 0, 0, STAT_OK, 0, 0, 0));
    directed_plan.push_back(row(MODE_PEEK, 32'h0, 0, 0, STAT_OK, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      p = directed_plan[i];
      send_request(p.mode, p.value, p.typed_in, p.want);
    end

    // mixed traffic, leaning toward growth
    repeat (30) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_random(any_push());
        4, 5, 6:    send_random(any_pop());
        default:    send_random(MODE_W'($urandom_range(0, 7)));
      endcase
    end

    // fill to the brim with no idling on either side, then push into a full stack
    steady = 1'b1;
    while (held < DEPTH) send_random(any_push());
    repeat (4) send_random(any_push());
    steady = 1'b0;

    // drain with the odd push or peek mixed in, then pop an empty stack
    while (held > 0) begin
      extra = $urandom_range(0, 99);
      if (extra < 88) send_random(any_pop());
      else if (extra < 94) send_random(any_push());
      else send_random(MODE_W'($urandom_range(0, 7)));
    end
    repeat (3) send_random(any_pop());

    repeat (30) send_random(MODE_W'($urandom_range(0, 7)));

    req_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
